@@ design/fbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbd_pkg
// Shared types and constants of the firmware block descrambler.
// ----------------------------------------------------------------------------
`default_nettype none

package fbd_pkg;

  localparam int unsigned MAX_SECTORS        = 8192;
  localparam int unsigned STRIP_PREFIX_BYTES = 32;

  localparam int unsigned BODY_LEN_W   = 23;
  localparam int unsigned SECT_CNT_W   = 14;
  localparam int unsigned TBL_POS_W    = 14;
  localparam int unsigned PREFIX_W     = 24;
  localparam int unsigned SECT_AW      = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam int unsigned MAX_RESULTS  = 6;
  localparam int unsigned RES_IDX_W    = $clog2(MAX_RESULTS);
  localparam int unsigned FIFO_DEPTH   = 16;
  localparam int unsigned FIFO_AW      = $clog2(FIFO_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_BODY_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_MODE  = 1'b1;

  localparam logic [1:0] STRIP_ECHO = 2'd0;

  localparam logic [7:0] SCRAMBLE_KEY [16] = '{
    8'h7a, 8'h36, 8'hc4, 8'h43, 8'h49, 8'h6b, 8'h35, 8'h4e,
    8'ha3, 8'h46, 8'h25, 8'h84, 8'h4d, 8'h73, 8'h74, 8'h61
  };

  typedef enum logic [1:0] {
    PH_BODY,
    PH_TABLE,
    PH_DRAIN
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_RUNNING     = 3'd0,
    ST_DONE_OK     = 3'd1,
    ST_MISMATCH    = 3'd2,
    ST_BODY_SHORT  = 3'd3,
    ST_TABLE_SHORT = 3'd4
  } status_e;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                has_byte;
    logic [STATUS_W-1:0] status;
    logic                run_end;
  } res_t;

endpackage

`default_nettype wire

@@ design/firmware_block_descrambler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firmware_block_descrambler
// Chained XOR descrambler of a sectored firmware body with block rotation,
// prefix strip and per-sector checksum table check.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i/in_ready_o  | in_byte_i, end_of_file_i
//  out     | output    | out_valid_o/out_ready_i| out_byte_o, has_byte_o,
//          |           |                        | status_o, run_end_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One input word per cycle; each is decoded in the cycle it is accepted and its
// 0..6 result words go to a 16-entry result queue, drained one word per cycle.
// in_ready_o is high while the queue has room for six words, so the rate is
// set by the output side: 16 results per 16-byte block keeps it at 1 word/cycle.
// Results reach the output in the cycle after acceptance at the earliest.
// Reset clears all control state at once; the sector sum memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module firmware_block_descrambler (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [fbd_pkg::BYTE_W-1:0]       in_byte_i,
  input  wire logic                             end_of_file_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [fbd_pkg::BYTE_W-1:0]       out_byte_o,
  output logic                                  has_byte_o,
  output logic      [fbd_pkg::STATUS_W-1:0]     status_o,
  output logic                                  run_end_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [fbd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [fbd_pkg::BODY_LEN_W-1:0]   cfg_data_i
);

  import fbd_pkg::*;

  function automatic logic strip_hit(input logic [1:0] mode,
                                     input logic [BODY_LEN_W-1:0] slot);
    return mode[1] && ({1'b0, slot} < PREFIX_W'(STRIP_PREFIX_BYTES));
  endfunction

  // registers
  logic [BODY_LEN_W-1:0] body_len_q;
  logic [1:0]            strip_q;
  logic [7:0]            chain_q [16];
  logic [7:0]            chain_d [16];
  logic [7:0]            held_q [4];
  logic [7:0]            held_d [4];
  logic [3:0]            byte_in_block_q, byte_in_block_d;
  logic [4:0]            blk_q, blk_d;
  logic [7:0]            sum_q, sum_d;
  logic [BODY_LEN_W-1:0] body_pos_q, body_pos_d;
  logic [TBL_POS_W-1:0]  tbl_pos_q, tbl_pos_d;
  phase_e                phase_q, phase_d;

  // datapath
  logic                  accept;
  logic [SECT_CNT_W-1:0] sectors;
  logic [BODY_LEN_W-1:0] blen;
  logic [3:0]            k;
  logic [7:0]            keyed, dec, expect_sum;
  logic [BODY_LEN_W-1:0] base, body_pos_inc;
  logic [TBL_POS_W-1:0]  tbl_pos_inc;
  logic                  eff_table;
  logic                  clear_stream;
  status_e               st;
  logic [RES_IDX_W-1:0]  last_idx;

  logic                   ram_we;
  logic [SECT_AW-1:0]     ram_waddr;
  logic [7:0]             ram_wdata;
  logic [7:0]             ram_rdata;

  logic [MAX_RESULTS-1:0] push_valid;
  res_t                   push_data [MAX_RESULTS];
  res_t                   out_data;
  logic                   room;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = room;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (body_len_q[BODY_LEN_W-1:9] > SECT_CNT_W'(MAX_SECTORS)) begin
      sectors = SECT_CNT_W'(MAX_SECTORS);
    end else begin
      sectors = body_len_q[BODY_LEN_W-1:9];
    end
  end

  assign blen         = {sectors, 9'b0};
  assign k            = byte_in_block_q;
  assign keyed        = in_byte_i ^ SCRAMBLE_KEY[k];
  assign dec          = keyed ^ chain_q[k];
  assign base         = {body_pos_q[BODY_LEN_W-1:4], 4'b0};
  assign body_pos_inc = body_pos_q + 1'b1;
  assign tbl_pos_inc  = tbl_pos_q + 1'b1;
  assign expect_sum   = (tbl_pos_q >= TBL_POS_W'(MAX_SECTORS)) ? 8'h00 : ram_rdata;
  assign eff_table    = (phase_q == PH_TABLE) || (body_pos_q >= blen);

  always_comb begin
    chain_d         = chain_q;
    held_d          = held_q;
    byte_in_block_d = byte_in_block_q;
    blk_d           = blk_q;
    sum_d           = sum_q;
    body_pos_d      = body_pos_q;
    tbl_pos_d       = tbl_pos_q;
    phase_d         = phase_q;
    clear_stream    = 1'b0;
    st              = ST_RUNNING;
    ram_we          = 1'b0;
    ram_waddr       = body_pos_q[SECT_AW+8:9];
    ram_wdata       = sum_q + dec;
    push_valid      = '0;
    last_idx        = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      push_data[i] = '0;
    end

    if (accept) begin
      case (phase_q)
        PH_DRAIN: begin
          clear_stream = end_of_file_i;
        end
        default: begin
          if (eff_table && ({1'b0, tbl_pos_q} >= {1'b0, sectors})) begin
            st = ST_DONE_OK;
          end else if (!eff_table) begin
            chain_d[k] = keyed;
            sum_d      = sum_q + dec;
            if (k < 4'd4) begin
              held_d[k[1:0]] = dec;
            end else begin
              push_valid[0]         = !strip_hit(strip_q, base + BODY_LEN_W'(k) - 4'd4);
              push_data[0].out_byte = dec;
              push_data[0].has_byte = 1'b1;
            end
            if (k == 4'd15) begin
              // head of the block goes out after its tail
              for (int j = 0; j < 4; j++) begin
                push_valid[1+j]         = !strip_hit(strip_q, base + BODY_LEN_W'(12 + j));
                push_data[1+j].out_byte = held_q[j];
                push_data[1+j].has_byte = 1'b1;
              end
              if (blk_q == 5'd31) begin
                // sector done: store its sum, restart the chain
                ram_we  = 1'b1;
                sum_d   = 8'h00;
                chain_d = '{default: 8'h00};
              end
              blk_d = blk_q + 1'b1;
            end
            byte_in_block_d = k + 1'b1;
            body_pos_d      = body_pos_inc;
            if (body_pos_inc >= blen) begin
              phase_d = PH_TABLE;
              if (end_of_file_i) begin
                st = ST_TABLE_SHORT;
              end
            end else if (end_of_file_i) begin
              st = ST_BODY_SHORT;
            end
          end else begin
            phase_d = PH_TABLE;
            if (strip_q == STRIP_ECHO) begin
              push_valid[0]         = 1'b1;
              push_data[0].out_byte = in_byte_i;
              push_data[0].has_byte = 1'b1;
            end
            tbl_pos_d = tbl_pos_inc;
            if (in_byte_i != expect_sum) begin
              st = ST_MISMATCH;
            end else if ({1'b0, tbl_pos_inc} >= {1'b0, sectors}) begin
              st = ST_DONE_OK;
            end else if (end_of_file_i) begin
              st = ST_TABLE_SHORT;
            end
          end

          if (st != ST_RUNNING) begin
            push_valid[MAX_RESULTS-1]       = 1'b1;
            push_data[MAX_RESULTS-1].status = st;
            if (end_of_file_i) begin
              clear_stream = 1'b1;
            end else begin
              phase_d = PH_DRAIN;
            end
          end
        end
      endcase
    end

    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (push_valid[i]) begin
        last_idx = RES_IDX_W'(i);
      end
    end
    if (push_valid != '0) begin
      push_data[last_idx].run_end = 1'b1;
    end

    if (clear_stream) begin
      chain_d         = '{default: 8'h00};
      held_d          = '{default: 8'h00};
      byte_in_block_d = '0;
      blk_d           = '0;
      sum_d           = '0;
      body_pos_d      = '0;
      tbl_pos_d       = '0;
      phase_d         = PH_BODY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_len_q      <= '0;
      strip_q         <= '0;
      chain_q         <= '{default: 8'h00};
      held_q          <= '{default: 8'h00};
      byte_in_block_q <= '0;
      blk_q           <= '0;
      sum_q           <= '0;
      body_pos_q      <= '0;
      tbl_pos_q       <= '0;
      phase_q         <= PH_BODY;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_BODY_LENGTH: body_len_q <= cfg_data_i;
          CFG_STRIP_MODE:  strip_q    <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      chain_q         <= chain_d;
      held_q          <= held_d;
      byte_in_block_q <= byte_in_block_d;
      blk_q           <= blk_d;
      sum_q           <= sum_d;
      body_pos_q      <= body_pos_d;
      tbl_pos_q       <= tbl_pos_d;
      phase_q         <= phase_d;
    end
  end

  // read address runs one step ahead so the expected sum is ready on the next word
  fbd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_SECTORS)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (tbl_pos_d[SECT_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  fbd_res_fifo u_res_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .room_o       (room),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data)
  );

  assign out_byte_o = out_data.out_byte;
  assign has_byte_o = out_data.has_byte;
  assign status_o   = out_data.status;
  assign run_end_o  = out_data.run_end;

  a_status_word_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> (status_o != ST_RUNNING) && run_end_o)
    else $error("status word without status code or run end");

  a_byte_word_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_byte_o |-> (status_o == ST_RUNNING))
    else $error("byte word carries a status code");

  a_sector_close_clears_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (sum_q == 8'h00) && (chain_q[0] == 8'h00))
    else $error("sector sum or chain not cleared at sector end");

  a_drain_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DRAIN) && accept && !end_of_file_i |=> (phase_q == PH_DRAIN))
    else $error("left drain before end of file");

endmodule

`default_nettype wire

@@ design/fbd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbd_ram
// Generic single-write, single-read RAM with registered read data.
// A read of the address being written returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module fbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/fbd_res_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbd_res_fifo
// Result queue: takes up to MAX_RESULTS words per cycle, packs them in order,
// and hands out one word per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module fbd_res_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [fbd_pkg::MAX_RESULTS-1:0] push_valid_i,
  input  fbd_pkg::res_t      push_data_i [fbd_pkg::MAX_RESULTS],
  output logic               room_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output fbd_pkg::res_t      out_data_o
);

  import fbd_pkg::*;

  res_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, wptr_d;
  logic [FIFO_AW-1:0] rptr_q, rptr_d;
  logic [FIFO_AW:0]   count_q, count_d;

  logic [FIFO_AW-1:0]     wr_idx [MAX_RESULTS];
  logic [MAX_RESULTS-1:0] wr_en;
  logic [RES_IDX_W:0]     push_cnt;
  logic                   pop;

  // pack the valid words to consecutive slots
  always_comb begin
    push_cnt = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      wr_idx[i] = wptr_q + FIFO_AW'(push_cnt);
      wr_en[i]  = push_valid_i[i];
      if (push_valid_i[i]) begin
        push_cnt = push_cnt + 1'b1;
      end
    end
  end

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = (count_q <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_RESULTS));

  always_comb begin
    wptr_d  = wptr_q + FIFO_AW'(push_cnt);
    rptr_d  = rptr_q + FIFO_AW'(pop);
    count_d = count_q + (FIFO_AW+1)'(push_cnt) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (wr_en[i]) begin
        mem_q[wr_idx[i]] <= push_data_i[i];
      end
    end
  end

endmodule

`default_nettype wire
